@@ hw/rtl/dqv_pkg.sv @@
// ---------------------------------------------------------------------------
// dqv_pkg: shared types and codes for the value-removal deque
// Operation and status codes, fixed field widths and the per-cell control
// bundle that the top level broadcasts to every cell.
// ---------------------------------------------------------------------------
package dqv_pkg;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IO_W     = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Already qualified by full/empty and by the handshake.
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic take_front;
    logic remove;
  } ctrl_t;

endpackage

@@ hw/rtl/dqv_in_if.sv @@
// ---------------------------------------------------------------------------
// dqv_in_if: request channel of the deque
// Valid/ready channel carrying the operation and its value.
// ---------------------------------------------------------------------------
interface dqv_in_if;
  logic                        valid;
  logic                        ready;
  logic [dqv_pkg::MODE_W-1:0]  mode;
  logic signed [dqv_pkg::IO_W-1:0] value_in;

  modport source (output valid, output mode, output value_in, input ready);
  modport sink   (input valid, input mode, input value_in, output ready);
endinterface

@@ hw/rtl/dqv_out_if.sv @@
// ---------------------------------------------------------------------------
// dqv_out_if: result channel of the deque
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface dqv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dqv_pkg::IO_W-1:0]   value_out;
  logic [dqv_pkg::STATUS_W-1:0]      status;
  logic [dqv_pkg::COUNT_W-1:0]       count;
  logic                              is_empty;

  modport source (output valid, output value_out, output status, output count,
                  output is_empty, input ready);
  modport sink   (input valid, input value_out, input status, input count,
                  input is_empty, output ready);
endinterface

@@ hw/rtl/deque_with_value_removal.sv @@
// ---------------------------------------------------------------------------
// deque_with_value_removal: bounded deque with removal by value
// A row of shifting cells, position 0 at the front, plus an occupancy
// counter and a registered result stage.
// ---------------------------------------------------------------------------
//  Channel   Dir   Handshake        Payload
//  in_ch     in    valid / ready    mode, value_in
//  out_ch    out   valid / ready    value_out, status, count, is_empty
//
//  Each request updates the cells and the result register together: the cells shift in parallel and the
//  match and tail reads ripple through the row in the same cycle.
//  One request per cycle is sustained while out_ch takes each result.
//  A new request is taken while the held result is being taken.
//  When out_ch stalls with a result held, in_ch is held off.
//  Synchronous reset empties the deque; cell contents are left as they are.
// ---------------------------------------------------------------------------
module deque_with_value_removal #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  dqv_in_if.sink     in_ch,
  dqv_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  accept;
  logic                  is_full;
  logic                  is_emp;
  logic [DATA_WIDTH-1:0] val_w;
  logic [DATA_WIDTH-1:0] pop_data;
  logic [dqv_pkg::IO_W-1:0] pop_ext;
  dqv_pkg::ctrl_t        ctrl;
  dqv_pkg::status_t      status_nxt;
  logic                  pop_ok;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  hit      [DEPTH+1];
  logic [DATA_WIDTH-1:0] tail     [DEPTH+1];

  logic                          out_valid_r;
  logic [dqv_pkg::IO_W-1:0]      value_out_r;
  logic [dqv_pkg::STATUS_W-1:0]  status_r;
  logic [dqv_pkg::COUNT_W-1:0]   count_r;
  logic                          is_empty_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = cnt_r == FULL_CNT;
  assign is_emp      = cnt_r == '0;

  generate
    if (DATA_WIDTH <= dqv_pkg::IO_W) begin : g_val_narrow
      assign val_w = in_ch.value_in[DATA_WIDTH-1:0];
    end else begin : g_val_wide
      assign val_w = {{(DATA_WIDTH - dqv_pkg::IO_W){1'b0}}, in_ch.value_in};
    end
  endgenerate

  always_comb begin
    ctrl.ins_front  = accept && in_ch.mode == dqv_pkg::MODE_PUSH_FRONT && !is_full;
    ctrl.ins_back   = accept && in_ch.mode == dqv_pkg::MODE_PUSH_BACK && !is_full;
    ctrl.take_front = accept && in_ch.mode == dqv_pkg::MODE_POP_FRONT && !is_emp;
    ctrl.remove     = accept && in_ch.mode == dqv_pkg::MODE_REMOVE;
  end

  assign hit[0]  = 1'b0;
  assign tail[0] = '0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
        assign left_d = val_w;
      end else begin : g_mid_l
        assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_d = cell_data[i];
      end else begin : g_mid_r
        assign right_d = cell_data[i+1];
      end

      dqv_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX        (i)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .cnt_i   (cnt_r),
        .val_i   (val_w),
        .left_i  (left_d),
        .right_i (right_d),
        .hit_i   (hit[i]),
        .tail_i  (tail[i]),
        .data_o  (cell_data[i]),
        .hit_o   (hit[i+1]),
        .tail_o  (tail[i+1])
      );
    end
  endgenerate

  always_comb begin
    pop_data   = '0;
    pop_ok     = 1'b0;
    cnt_nxt    = cnt_r;
    status_nxt = dqv_pkg::ST_OK;
    unique case (in_ch.mode)
      dqv_pkg::MODE_PUSH_FRONT, dqv_pkg::MODE_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = dqv_pkg::ST_FULL;
        end else begin
          cnt_nxt = cnt_r + ONE;
        end
      end
      dqv_pkg::MODE_POP_FRONT, dqv_pkg::MODE_POP_BACK: begin
        if (is_emp) begin
          status_nxt = dqv_pkg::ST_EMPTY;
        end else begin
          pop_ok   = 1'b1;
          pop_data = (in_ch.mode == dqv_pkg::MODE_POP_FRONT) ? cell_data[0] : tail[DEPTH];
          cnt_nxt  = cnt_r - ONE;
        end
      end
      dqv_pkg::MODE_REMOVE: begin
        if (hit[DEPTH]) begin
          cnt_nxt = cnt_r - ONE;
        end else begin
          status_nxt = dqv_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Popped values are sign-extended from the storage width when it is narrower than the output, else truncated.
  generate
    if (DATA_WIDTH >= dqv_pkg::IO_W) begin : g_out_wide
      assign pop_ext = pop_data[dqv_pkg::IO_W-1:0];
    end else begin : g_out_narrow
      assign pop_ext = {{(dqv_pkg::IO_W - DATA_WIDTH){pop_data[DATA_WIDTH-1]}}, pop_data};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      value_out_r <= pop_ok ? pop_ext : '0;
      status_r    <= status_nxt;
      count_r     <= dqv_pkg::COUNT_W'(cnt_nxt);
      is_empty_r  <= cnt_nxt == '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = value_out_r;
  assign out_ch.status    = status_r;
  assign out_ch.count     = count_r;
  assign out_ch.is_empty  = is_empty_r;

endmodule

@@ hw/rtl/dqv_cell.sv @@
// ---------------------------------------------------------------------------
// dqv_cell: one storage position of the deque
// Holds one element, compares it with the request value and passes the
// match and tail-read chains on to the next position.
// ---------------------------------------------------------------------------
module dqv_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  dqv_pkg::ctrl_t        ctrl,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [DATA_WIDTH-1:0] val_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic                  hit_i,
  input  logic [DATA_WIDTH-1:0] tail_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] tail_o
);

  localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  occupied;
  logic                  is_tail;

  assign occupied = MY_IDX < cnt_i;
  assign is_tail  = NEXT_IDX == cnt_i;

  // The hit chain is set from the front-most match onward; every position
  // at or behind it closes the gap by taking its right neighbor.
  assign hit_o  = hit_i | (occupied && data_r == val_i);
  assign tail_o = tail_i | (is_tail ? data_r : '0);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_front) begin
      data_nxt = (IDX == 0) ? val_i : left_i;
    end else if (ctrl.ins_back && MY_IDX == cnt_i) begin
      data_nxt = val_i;
    end else if (ctrl.take_front || (ctrl.remove && hit_o)) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ hw/rtl/dqv_checker.sv @@
// ---------------------------------------------------------------------------
// dqv_checker: port-level checks for the value-removal deque
// Watches the result channel for consistency between status, count and
// value, and for a held result while the channel stalls.
// ---------------------------------------------------------------------------
module dqv_checker #(
  parameter int DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [dqv_pkg::IO_W-1:0]         out_value,
  input logic [dqv_pkg::STATUS_W-1:0]     out_status,
  input logic [dqv_pkg::COUNT_W-1:0]      out_count,
  input logic                             out_is_empty
);

  localparam logic [dqv_pkg::COUNT_W-1:0] FULL_CNT = dqv_pkg::COUNT_W'(DEPTH);

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("is_empty disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == dqv_pkg::ST_FULL) |-> out_count == FULL_CNT)
    else $error("full status reported below capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == dqv_pkg::ST_EMPTY) |-> (out_is_empty && out_value == '0))
    else $error("empty pop with data or nonzero count");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != dqv_pkg::ST_OK) |-> out_value == '0)
    else $error("failed request returned a value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_count)))
    else $error("stalled result changed");

endmodule

bind deque_with_value_removal dqv_checker #(
  .DEPTH (DEPTH)
) u_dqv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value_out),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count),
  .out_is_empty (out_ch.is_empty)
);
